>>> rtl/least_loaded_worker_binder_defines.svh
// ----------------------------------------------------------------------------
// least_loaded_worker_binder_defines
// assertion macros used by the binder top level
// ----------------------------------------------------------------------------
`ifndef LEAST_LOADED_WORKER_BINDER_DEFINES_SVH
`define LEAST_LOADED_WORKER_BINDER_DEFINES_SVH

// same-cycle implication, held off during reset
`define LLWB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define LLWB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/llwb_pkg.sv
// ----------------------------------------------------------------------------
// llwb_pkg
// types, codes and defaults for the least loaded worker binder
// ----------------------------------------------------------------------------
package llwb_pkg;

    localparam int DEF_MAX_WORKERS = 16;
    localparam int DEF_COUNT_BITS  = 16;

    localparam logic [4:0] ACTIVE_RESET = 5'd16;

    localparam logic OP_BIND   = 1'b0;
    localparam logic OP_UNBIND = 1'b1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_WORKER = 2'd1;
    localparam logic [1:0] ST_FULL       = 2'd2;
    localparam logic [1:0] ST_UNDERFLOW  = 2'd3;

    localparam logic REG_ACTIVE_WORKERS = 1'b0;

    typedef struct packed {
        logic       operation;
        logic [4:0] worker_number;
    } t_in_item;

    typedef struct packed {
        logic [4:0] assigned_worker;
        logic [1:0] status;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic scan;
        logic unb_rd;
        logic resolve;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic op;
        logic n_zero;
        logic num_bad;
        logic scan_last;
    } t_dp_stat;

endpackage

>>> rtl/llwb_ctrl.sv
// ----------------------------------------------------------------------------
// llwb_ctrl
// sequencer for bind scan, unbind read, counter update and result hand-off
// ----------------------------------------------------------------------------
module llwb_ctrl
    import llwb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_in_stall,
    output logic     o_out_valid
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DECIDE  = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_CMPW    = 3'd3;
    localparam logic [2:0] S_UREAD   = 3'd4;
    localparam logic [2:0] S_RESOLVE = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    t_dp_cmd    c_cmd;

    always_comb begin
        n_state = r_state;
        c_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    c_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.op == OP_BIND) begin
                    n_state = i_stat.n_zero ? S_RESOLVE : S_SCAN;
                end else begin
                    n_state = i_stat.num_bad ? S_RESOLVE : S_UREAD;
                end
            end
            S_SCAN: begin
                c_cmd.scan = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_CMPW;
                end
            end
            S_CMPW: begin
                n_state = S_RESOLVE;
            end
            S_UREAD: begin
                c_cmd.unb_rd = 1'b1;
                n_state      = S_RESOLVE;
            end
            S_RESOLVE: begin
                c_cmd.resolve = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    c_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (c_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = c_cmd;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/llwb_datapath.sv
// ----------------------------------------------------------------------------
// llwb_datapath
// counter memory, running minimum, counter update and result register
// ----------------------------------------------------------------------------
module llwb_datapath
    import llwb_pkg::*;
#(
    parameter int MAX_WORKERS = DEF_MAX_WORKERS,
    parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  t_in_item   i_in_data,
    input  logic [4:0] i_active_workers,
    output t_dp_stat   o_stat,
    output t_out_item  o_out_data
);

    localparam int WIDX = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int NCAP = (MAX_WORKERS < 31) ? MAX_WORKERS : 31;
    localparam logic [4:0]            NCAP5     = 5'(NCAP);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] r_count [MAX_WORKERS];
    logic [MAX_WORKERS-1:0] r_valid;

    logic                  r_op;
    logic [4:0]            r_num;
    logic [4:0]            r_scan_idx;
    logic [4:0]            r_cmp_idx;
    logic                  r_cmp_vld;
    logic [COUNT_BITS-1:0] r_rd_data;
    logic                  r_rd_vld;
    logic                  r_found;
    logic [4:0]            r_best_idx;
    logic [COUNT_BITS-1:0] r_best_cnt;
    t_out_item             r_res;
    t_out_item             r_out;

    logic [4:0]            c_n;
    logic                  c_num_bad;
    logic                  c_rd_en;
    logic [WIDX-1:0]       c_rd_addr;
    logic [COUNT_BITS-1:0] c_cur;
    logic                  c_better;
    logic                  c_w_en;
    logic [WIDX-1:0]       c_w_addr;
    logic [COUNT_BITS-1:0] c_w_data;
    t_out_item             c_res;

    assign c_n       = (i_active_workers > NCAP5) ? NCAP5 : i_active_workers;
    assign c_num_bad = (r_num == 5'd0) || (r_num > c_n);
    assign c_cur     = r_rd_vld ? r_rd_data : '0;
    assign c_better  = !r_found || (c_cur < r_best_cnt);

    always_comb begin
        c_rd_en   = 1'b0;
        c_rd_addr = WIDX'(r_scan_idx);
        if (i_cmd.scan) begin
            c_rd_en = 1'b1;
        end else if (i_cmd.unb_rd) begin
            c_rd_en   = 1'b1;
            c_rd_addr = WIDX'(5'(r_num - 5'd1));
        end
    end

    always_comb begin
        c_w_en   = 1'b0;
        c_w_addr = WIDX'(r_best_idx);
        c_w_data = r_best_cnt + COUNT_BITS'(1);
        c_res    = '{assigned_worker: 5'd0, status: ST_OK};
        if (r_op == OP_BIND) begin
            if (!r_found || (r_best_cnt == COUNT_MAX)) begin
                c_res.status = ST_FULL;
            end else begin
                c_w_en                = i_cmd.resolve;
                c_res.assigned_worker = 5'(r_best_idx + 5'd1);
            end
        end else begin
            c_w_addr = WIDX'(5'(r_num - 5'd1));
            c_w_data = c_cur - COUNT_BITS'(1);
            if (c_num_bad) begin
                c_res.status = ST_BAD_WORKER;
            end else if (c_cur == '0) begin
                c_res.status = ST_UNDERFLOW;
            end else begin
                c_w_en = i_cmd.resolve;
            end
        end
    end

    // counter memory
    always_ff @(posedge i_clk) begin
        if (c_w_en) begin
            r_count[c_w_addr] <= c_w_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_rd_en) begin
            r_rd_data <= r_count[c_rd_addr];
        end
    end

    // entry valid bits, an unwritten counter reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (c_w_en) begin
                r_valid[c_w_addr] <= 1'b1;
            end
            if (c_rd_en) begin
                r_rd_vld <= r_valid[c_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_in_data.operation;
            r_num      <= i_in_data.worker_number;
            r_scan_idx <= 5'd0;
            r_found    <= 1'b0;
        end else begin
            if (i_cmd.scan) begin
                r_scan_idx <= 5'(r_scan_idx + 5'd1);
                r_cmp_idx  <= r_scan_idx;
            end
            // running minimum, ties keep the lower index
            if (r_cmp_vld && c_better) begin
                r_found    <= 1'b1;
                r_best_idx <= r_cmp_idx;
                r_best_cnt <= c_cur;
            end
        end
        if (i_cmd.resolve) begin
            r_res <= c_res;
        end
        if (i_cmd.emit) begin
            r_out <= r_res;
        end
    end

    assign o_stat.op        = r_op;
    assign o_stat.n_zero    = (c_n == 5'd0);
    assign o_stat.num_bad   = c_num_bad;
    assign o_stat.scan_last = (r_scan_idx == 5'(c_n - 5'd1));
    assign o_out_data       = r_out;

endmodule

>>> rtl/least_loaded_worker_binder.sv
// ----------------------------------------------------------------------------
// least_loaded_worker_binder
// binds sessions to the worker with the fewest bindings, unbinds on request
//
//   channel   direction  handshake                   payload
//   input     in         i_in_valid / o_in_stall     i_in_data  (t_in_item)
//   output    out        o_out_valid / i_out_stall   o_out_data (t_out_item)
//   config    in         psel penable pwrite pready  paddr pwdata / prdata
//
// bind: items one at a time, scanning the counters of n active workers (none with
// none), one counter read a cycle from the counter memory; unbind: one counter read
// synchronous active-low reset clears all counters and sets 16 active workers
// the next item is taken while a finished result waits under output stall
// ----------------------------------------------------------------------------
`include "least_loaded_worker_binder_defines.svh"

module least_loaded_worker_binder
    import llwb_pkg::*;
#(
    parameter int MAX_WORKERS = DEF_MAX_WORKERS,
    parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [4:0] r_active_workers;
    t_dp_cmd    w_cmd;
    t_dp_stat   w_stat;
    logic       c_cfg_wr;

    assign pready   = 1'b1;
    assign c_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_workers <= ACTIVE_RESET;
        end else if (c_cfg_wr && (paddr[2] == REG_ACTIVE_WORKERS)) begin
            r_active_workers <= pwdata[4:0];
        end
    end

    assign prdata = (paddr[2] == REG_ACTIVE_WORKERS) ? {27'd0, r_active_workers} : 32'd0;

    llwb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    llwb_datapath #(
        .MAX_WORKERS (MAX_WORKERS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_in_data        (i_in_data),
        .i_active_workers (r_active_workers),
        .o_stat           (w_stat),
        .o_out_data       (o_out_data)
    );

    `LLWB_ASSERT_NXT(a_busy_after_transfer, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input taken but block not busy")
    `LLWB_ASSERT_IMP(a_emit_slot_free, i_clk, i_rst_n, w_cmd.emit, !o_out_valid || !i_out_stall, "result overwrites a waiting result")
    `LLWB_ASSERT_IMP(a_cmd_onehot, i_clk, i_rst_n, 1'b1, $onehot0(w_cmd), "more than one datapath command")
    `LLWB_ASSERT_IMP(a_result_from_busy, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall), "result without an item in work")

endmodule

>>> sim/least_loaded_worker_binder_checker.sv
// ----------------------------------------------------------------------------
// least_loaded_worker_binder_checker
// watches the binder's channels and its register port, keeps its own copy of
// the binding counters and the active worker count, works out the result of
// every accepted request and compares each returned result with the oldest
// one still owed
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module least_loaded_worker_binder_checker
    import llwb_pkg::*;
#(
    parameter int MAX_WORKERS = DEF_MAX_WORKERS,
    parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_item    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_item   i_out_data,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    input  logic        i_pready,
    output int          o_pending,
    output int          o_fail_count,
    output int          o_checked
);

    localparam logic [COUNT_BITS-1:0] COUNT_FULL  = '1;
    localparam logic [2:0]            ADDR_ACTIVE = {REG_ACTIVE_WORKERS, 2'b00};

    logic [COUNT_BITS-1:0] bind_count [MAX_WORKERS];
    logic [4:0]            active_workers;
    t_out_item             owed_results [$];
    int                    fails   = 0;
    int                    checked = 0;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
        o_checked    = 0;
    end

    function automatic int live_workers();
        return (active_workers > MAX_WORKERS) ? MAX_WORKERS : int'(active_workers);
    endfunction

    task automatic predict_binding(input t_in_item req, output t_out_item res);
        int n;
        int best;
        n = live_workers();
        best = 0;
        res.assigned_worker = '0;
        res.status = ST_OK;
        if (req.operation == OP_BIND) begin
            if (n == 0) begin
                res.status = ST_FULL;
            end else begin
                for (int i = 1; i < n; i++) begin
                    if (bind_count[i] < bind_count[best]) begin
                        best = i;
                    end
                end
                if (bind_count[best] == COUNT_FULL) begin
                    res.status = ST_FULL;
                end else begin
                    bind_count[best] = bind_count[best] + 1'b1;
                    res.assigned_worker = 5'(best + 1);
                end
            end
        end else if (req.worker_number == 0 || int'(req.worker_number) > n) begin
            res.status = ST_BAD_WORKER;
        end else if (bind_count[req.worker_number - 1] == '0) begin
            res.status = ST_UNDERFLOW;
        end else begin
            bind_count[req.worker_number - 1] = bind_count[req.worker_number - 1] - 1'b1;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item owed;
        t_out_item fresh;
        if (!i_rst_n) begin
            owed_results.delete();
            active_workers = ACTIVE_RESET;
            for (int i = 0; i < MAX_WORKERS; i++) begin
                bind_count[i] = '0;
            end
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr == ADDR_ACTIVE) begin
                        active_workers = i_pwdata[4:0];
                    end
                end else if (i_paddr == ADDR_ACTIVE && i_prdata !== 32'(active_workers)) begin
                    $error("prdata mismatch: expected %0d, got %0d", active_workers, i_prdata);
                    fails++;
                end
            end
            // result transfer before request transfer, a result never comes in the same cycle
            if (i_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    $error("result transfer with nothing owed: assigned_worker %0d, status %0d",
                           i_out_data.assigned_worker, i_out_data.status);
                    fails++;
                end else begin
                    owed = owed_results.pop_front();
                    checked++;
                    if (i_out_data.assigned_worker !== owed.assigned_worker) begin
                        $error("assigned_worker mismatch: expected %0d, got %0d",
                               owed.assigned_worker, i_out_data.assigned_worker);
                        fails++;
                    end
                    if (i_out_data.status !== owed.status) begin
                        $error("status mismatch: expected %0d, got %0d",
                               owed.status, i_out_data.status);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_binding(i_in_data, fresh);
                owed_results.push_back(fresh);
            end
        end
        o_pending    <= owed_results.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

>>> sim/least_loaded_worker_binder_tb.sv
// ----------------------------------------------------------------------------
// least_loaded_worker_binder_tb
// drives bind and unbind requests and register writes into the binder, with
// random gaps and output stalls, a long output hold-off, and one gap-free
// burst on a single worker; the checker beside the block
// owns all result comparison, this module only gives the verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module least_loaded_worker_binder_tb;
    import llwb_pkg::*;

    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 24;
    localparam int TAIL_CYCLES   = 40;
    localparam int PHASE_ITEMS   = 110;
    localparam int FILL_BINDS    = 40;

    localparam logic [2:0] ADDR_ACTIVE = {REG_ACTIVE_WORKERS, 2'b00};
    // no register behind this address
    localparam logic [2:0] ADDR_SPARE  = 3'd4;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_in_item    i_in_data   = '0;
    logic        i_out_stall = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_data;
    logic [31:0] prdata;
    logic        pready;

    int   owed_count;
    int   fail_count;
    int   checked_count;
    int   cycles      = 0;
    int   items_sent  = 0;
    int   fill_sent   = 0;
    int   cfg_writes  = 0;
    bit   tx_idle     = 1'b1;
    logic rx_idle_en  = 1'b0;
    logic hold_go     = 1'b0;
    int   hold_left   = 0;

    always #10 i_clk = ~i_clk;

    least_loaded_worker_binder u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    least_loaded_worker_binder_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_prdata    (prdata),
        .i_pready    (pready),
        .o_pending   (owed_count),
        .o_fail_count(fail_count),
        .o_checked   (checked_count)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // output side: long hold-off on request, otherwise random stalls
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= rx_idle_en && ($urandom_range(0, 99) < 19);
        end
    end

    function automatic t_in_item mk_item(input logic op, input logic [4:0] num);
        t_in_item req;
        req.operation     = op;
        req.worker_number = num;
        return req;
    endfunction

    function automatic int clamp_workers(input int v);
        return (v > DEF_MAX_WORKERS) ? DEF_MAX_WORKERS : v;
    endfunction

    // a bind or an unbind, unbinds mostly of live workers, so counters move both ways
    function automatic t_in_item rand_item(input int n);
        t_in_item req;
        req.operation     = ($urandom_range(0, 99) < 55) ? OP_BIND : OP_UNBIND;
        req.worker_number = 5'($urandom_range(0, 31));
        if (req.operation == OP_UNBIND && n > 0 && $urandom_range(0, 99) < 75) begin
            req.worker_number = 5'($urandom_range(1, n));
        end
        return req;
    endfunction

    task automatic push_item(input t_in_item req);
        while (tx_idle && $urandom_range(0, 99) < 19) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (owed_count != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_active(input logic [4:0] v);
        drain();
        cfg_access(1'b1, ADDR_ACTIVE, {27'($urandom), v});
        cfg_writes++;
        cfg_access(1'b0, ADDR_ACTIVE, '0);
    endtask

    initial begin : stimulus
        int act;
        int limit;
        repeat (4) @(posedge i_clk);
        i_rst_n    <= 1'b1;
        rx_idle_en <= 1'b1;
        @(posedge i_clk);

        // reset setting, sixteen workers
        push_item(mk_item(OP_BIND, 5'd0));
        push_item(mk_item(OP_BIND, 5'd31));
        push_item(mk_item(OP_BIND, 5'd21));
        push_item(mk_item(OP_UNBIND, 5'd1));
        push_item(mk_item(OP_UNBIND, 5'd1));
        push_item(mk_item(OP_UNBIND, 5'd0));
        push_item(mk_item(OP_UNBIND, 5'd17));
        push_item(mk_item(OP_UNBIND, 5'd31));
        push_item(mk_item(OP_UNBIND, 5'd16));
        push_item(mk_item(OP_UNBIND, 5'd2));
        push_item(mk_item(OP_BIND, 5'd10));

        // no live worker
        set_active(5'd0);
        push_item(mk_item(OP_BIND, 5'd0));
        push_item(mk_item(OP_UNBIND, 5'd1));

        // above the worker count, clamped
        set_active(5'd31);
        push_item(mk_item(OP_BIND, 5'd0));
        push_item(mk_item(OP_UNBIND, 5'd16));
        drain();
        cfg_access(1'b1, ADDR_SPARE, 32'd1);
        cfg_writes++;
        push_item(mk_item(OP_BIND, 5'd0));

        set_active(5'd1);
        push_item(mk_item(OP_BIND, 5'd0));
        push_item(mk_item(OP_UNBIND, 5'd2));
        push_item(mk_item(OP_UNBIND, 5'd1));

        // burst on worker one with no gaps or stalls
        drain();
        tx_idle     = 1'b0;
        rx_idle_en <= 1'b0;
        repeat (FILL_BINDS) push_item(mk_item(OP_BIND, 5'($urandom_range(0, 31))));
        fill_sent = FILL_BINDS;
        push_item(mk_item(OP_UNBIND, 5'd1));
        push_item(mk_item(OP_BIND, 5'd0));
        push_item(mk_item(OP_BIND, 5'd0));
        set_active(5'd2);
        push_item(mk_item(OP_BIND, 5'd0));
        push_item(mk_item(OP_BIND, 5'd0));
        tx_idle     = 1'b1;
        rx_idle_en <= 1'b1;

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: act = 16;
                1: act = 31;
                2: act = 1;
                3: act = $urandom_range(2, 15);
                4: act = 0;
                default: act = $urandom_range(0, 31);
            endcase
            set_active(5'(act));
            if (p == 0) begin
                hold_go <= 1'b1;
                @(posedge i_clk);
                hold_go <= 1'b0;
            end
            limit = (act == 0) ? 30 : PHASE_ITEMS;
            for (int k = 0; k < limit; k++) begin
                if (p == 1 && k == PHASE_ITEMS / 2) begin
                    drain();
                end
                push_item(rand_item(clamp_workers(act)));
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("summary: %0d request transfers (%0d in a gap-free burst on one worker)",
                 items_sent, fill_sent);
        $display("summary: %0d results checked, %0d register writes over 0, 1, 2, 16, 31 %s",
                 checked_count, cfg_writes, "and random worker counts, one long output hold-off");
        if (fail_count == 0 && owed_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
